// ===== rtl/wsfm_pkg.sv =====
// Shared constants, types and helper functions for the working set fault monitor.
package wsfm_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int PAGE_W       = 8;
  localparam int CFG_W        = 7;
  localparam int SET_W        = 7;
  localparam int TOTAL_W      = 32;
  localparam int WIN_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int GROUP_W      = 8;
  localparam int NGROUP       = (WINDOW_DEPTH + GROUP_W - 1) / GROUP_W;
  localparam int GSUM_W       = $clog2(GROUP_W + 1);
  localparam int SET_MAX      = (1 << SET_W) - 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic cmp;
    logic clear;
    logic shift;
  } cell_ctl_t;

  function automatic logic [WIN_W-1:0] window_clamp(input logic [CFG_W-1:0] cfg);
    int c;
    c = int'(cfg);
    if (c < 1) begin
      c = 1;
    end else if (c > WINDOW_DEPTH) begin
      c = WINDOW_DEPTH;
    end
    return WIN_W'(c);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

endpackage

// ===== rtl/wsfm_cell.sv =====
// One history cell: holds a page, its valid and duplicate flags, and a match flag.
module wsfm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wsfm_pkg::cell_ctl_t       ctl,
  input  logic [wsfm_pkg::PAGE_W-1:0] key,
  input  logic                      in_win,
  input  logic                      keep,
  input  logic [wsfm_pkg::PAGE_W-1:0] prev_page,
  input  logic                      prev_valid,
  input  logic                      prev_dup,
  input  logic                      prev_eq,
  output logic [wsfm_pkg::PAGE_W-1:0] page,
  output logic                      valid,
  output logic                      dup,
  output logic                      eq,
  output logic                      hit
);
  import wsfm_pkg::*;

  logic [PAGE_W-1:0] page_r;
  logic              valid_r;
  logic              dup_r;
  logic              hit_r;

  assign eq    = (page_r == key);
  assign page  = page_r;
  assign valid = valid_r;
  assign dup   = dup_r;
  assign hit   = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= prev_valid & keep;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      page_r <= prev_page;
      dup_r  <= prev_dup | prev_eq;
    end
    if (ctl.cmp) begin
      hit_r <= valid_r & ~ctl.clear & in_win & eq;
    end
  end

endmodule

// ===== rtl/wsfm_count.sv =====
// Registered population count of the cells that hold the newest copy of a page.
module wsfm_count (
  input  logic                             clk,
  input  logic                             load,
  input  logic [wsfm_pkg::WINDOW_DEPTH-1:0] live,
  output logic [wsfm_pkg::CNT_W-1:0]        total
);
  import wsfm_pkg::*;

  logic [NGROUP*GROUP_W-1:0] live_pad;
  logic [GSUM_W-1:0]         gsum_nxt [NGROUP];
  logic [GSUM_W-1:0]         gsum_r   [NGROUP];

  assign live_pad = (NGROUP * GROUP_W)'(live);

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      gsum_nxt[g] = '0;
      for (int b = 0; b < GROUP_W; b++) begin
        gsum_nxt[g] = gsum_nxt[g] + GSUM_W'(live_pad[g*GROUP_W + b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGROUP; g++) begin
        gsum_r[g] <= gsum_nxt[g];
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGROUP; g++) begin
      total = total + CNT_W'(gsum_r[g]);
    end
  end

endmodule

// ===== rtl/working_set_fault_monitor.sv =====
// Top level: working set fault monitor with a shifting chain of history cells.
// A request steps through match, shift, count and total before the next is taken;
// total holds while the output stalls; the sequencer steps cells and grouped count.
// Reset (synchronous, rst_n low): empty window, zero totals, window size 1.
// A new request is taken while the previous result still waits on the output.
module working_set_fault_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wsfm_pkg::PAGE_W-1:0]   in_page,
  input  logic                          in_start_run,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_page_fault,
  output logic [wsfm_pkg::SET_W-1:0]    out_set_size,
  output logic [wsfm_pkg::TOTAL_W-1:0]  out_fault_total,
  output logic [wsfm_pkg::TOTAL_W-1:0]  out_size_sum,
  output logic [wsfm_pkg::TOTAL_W-1:0]  out_reference_total,
  input  logic                          cfg_wr_en,
  input  logic [wsfm_pkg::CFG_W-1:0]    cfg_wr_data
);
  import wsfm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_CNT   = 2'd2;
  localparam logic [1:0] ST_SUM   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_window_r;
  logic [PAGE_W-1:0]  page_r;
  logic               start_r;
  logic               fault_r;
  logic               out_valid_r;
  logic               out_fault_r;
  logic [SET_W-1:0]   out_size_r;
  logic [TOTAL_W-1:0] faults_r, sizes_r, refs_r;

  logic               accept;
  logic               emit;
  logic [WIN_W-1:0]   win;
  cell_ctl_t          ctl;
  logic [PAGE_W-1:0]  key;
  logic [CNT_W-1:0]   count;
  logic [31:0]        count_ext;
  logic [SET_W-1:0]   set_size;
  logic [TOTAL_W-1:0] faults_base, sizes_base, refs_base;

  logic [PAGE_W-1:0]       c_page  [WINDOW_DEPTH+1];
  logic                    c_valid [WINDOW_DEPTH+1];
  logic                    c_dup   [WINDOW_DEPTH+1];
  logic                    c_eq    [WINDOW_DEPTH+1];
  logic [WINDOW_DEPTH-1:0] hit_vec;
  logic [WINDOW_DEPTH-1:0] live_vec;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign emit     = (state_r == ST_SUM) & (~out_valid_r | out_ready);
  assign win      = window_clamp(cfg_window_r);
  assign key      = (state_r == ST_IDLE) ? in_page : page_r;

  assign ctl.cmp   = accept;
  assign ctl.clear = accept & in_start_run;
  assign ctl.shift = (state_r == ST_SHIFT);

  // Chain head: the new reference enters as the newest copy of its page.
  assign c_page[0]  = page_r;
  assign c_valid[0] = 1'b1;
  assign c_dup[0]   = 1'b0;
  assign c_eq[0]    = 1'b0;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic in_win;
    logic keep;
    assign in_win = (WIN_W'(i) < win);
    assign keep   = (WIN_W'(i) < win);
    wsfm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (key),
      .in_win     (in_win),
      .keep       (keep),
      .prev_page  (c_page[i]),
      .prev_valid (c_valid[i]),
      .prev_dup   (c_dup[i]),
      .prev_eq    (c_eq[i]),
      .page       (c_page[i+1]),
      .valid      (c_valid[i+1]),
      .dup        (c_dup[i+1]),
      .eq         (c_eq[i+1]),
      .hit        (hit_vec[i])
    );
    assign live_vec[i] = c_valid[i+1] & ~c_dup[i+1];
  end

  wsfm_count u_count (
    .clk   (clk),
    .load  (state_r == ST_CNT),
    .live  (live_vec),
    .total (count)
  );

  assign count_ext   = 32'(count);
  assign set_size    = (count_ext > 32'(SET_MAX)) ? SET_W'(SET_MAX) : count_ext[SET_W-1:0];
  assign faults_base = start_r ? '0 : faults_r;
  assign sizes_base  = start_r ? '0 : sizes_r;
  assign refs_base   = start_r ? '0 : refs_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = ST_CNT;
      ST_CNT:   state_nxt = ST_SUM;
      ST_SUM:   if (emit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_window_r <= CFG_W'(1);
      out_valid_r  <= 1'b0;
      faults_r     <= '0;
      sizes_r      <= '0;
      refs_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_window_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        faults_r    <= sat_add(faults_base, TOTAL_W'(fault_r));
        sizes_r     <= sat_add(sizes_base, TOTAL_W'(set_size));
        refs_r      <= sat_add(refs_base, TOTAL_W'(1));
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_r  <= in_page;
      start_r <= in_start_run;
    end
    if (state_r == ST_SHIFT) begin
      fault_r <= ~|hit_vec;
    end
    if (emit) begin
      out_fault_r <= fault_r;
      out_size_r  <= set_size;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_page_fault      = out_fault_r;
  assign out_set_size        = out_size_r;
  assign out_fault_total     = faults_r;
  assign out_size_sum        = sizes_r;
  assign out_reference_total = refs_r;

endmodule

// ===== rtl/wsfm_checker.sv =====
// Port-level assertions for the working set fault monitor, with bind.
module wsfm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_page_fault,
  input logic [wsfm_pkg::SET_W-1:0]   out_set_size,
  input logic [wsfm_pkg::TOTAL_W-1:0] out_fault_total,
  input logic [wsfm_pkg::TOTAL_W-1:0] out_reference_total
);
  import wsfm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_set_size)
      && $stable(out_fault_total))
    else $error("result changed while stalled");

  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_page_fault |-> out_fault_total != '0)
    else $error("fault not counted in total");

  a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_set_size != '0 && 32'(out_set_size) <= 32'(WINDOW_DEPTH))
    else $error("set size out of range");

  a_faults_le_refs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fault_total <= out_reference_total)
    else $error("more faults than references");

endmodule

bind working_set_fault_monitor wsfm_checker u_wsfm_checker (.*);

// ===== tb/tb_working_set_fault_monitor.sv =====
// Self-checking testbench for the working set fault monitor: directed table, then random phases.
module tb_working_set_fault_monitor;
  import wsfm_pkg::*;

  localparam int NUM_ROWS   = 22;
  localparam int NUM_PHASES = 13;
  localparam int PHASE_REFS = 48;
  localparam int QUIET_FROM = 11;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SLOT_W = $clog2(WINDOW_DEPTH);

  typedef struct packed {
    logic               page_fault;
    logic [SET_W-1:0]   set_size;
    logic [TOTAL_W-1:0] fault_total;
    logic [TOTAL_W-1:0] size_sum;
    logic [TOTAL_W-1:0] reference_total;
  } ws_report_t;

  typedef struct packed {
    logic               set_window;
    logic [CFG_W-1:0]   window;
    logic [PAGE_W-1:0]  page;
    logic               start_run;
    logic               typed;
    ws_report_t         report;
  } page_row_t;

  localparam page_row_t PAGE_ROWS [NUM_ROWS] = '{
    '{1'b0, 7'd0,   8'h00, 1'b0, 1'b1, '{1'b1, 7'd1, 32'd1, 32'd1,  32'd1}},
    '{1'b0, 7'd0,   8'h00, 1'b0, 1'b1, '{1'b0, 7'd1, 32'd1, 32'd2,  32'd2}},
    '{1'b0, 7'd0,   8'hFF, 1'b0, 1'b1, '{1'b1, 7'd1, 32'd2, 32'd3,  32'd3}},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 1'b1, '{1'b1, 7'd1, 32'd1, 32'd1,  32'd1}},
    '{1'b1, 7'd0,   8'h80, 1'b0, 1'b1, '{1'b1, 7'd1, 32'd2, 32'd2,  32'd2}},
    '{1'b0, 7'd0,   8'h80, 1'b0, 1'b1, '{1'b0, 7'd1, 32'd2, 32'd3,  32'd3}},
    '{1'b1, 7'd127, 8'h01, 1'b0, 1'b1, '{1'b1, 7'd2, 32'd3, 32'd5,  32'd4}},
    '{1'b0, 7'd0,   8'h80, 1'b0, 1'b1, '{1'b0, 7'd2, 32'd3, 32'd7,  32'd5}},
    '{1'b0, 7'd0,   8'h7F, 1'b0, 1'b1, '{1'b1, 7'd3, 32'd4, 32'd10, 32'd6}},
    '{1'b0, 7'd0,   8'h55, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'hAA, 1'b0, 1'b0, '0},
    '{1'b1, 7'd2,   8'h7F, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'hAA, 1'b0, 1'b0, '0},
    '{1'b1, 7'd4,   8'h01, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h02, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h7F, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h01, 1'b0, 1'b0, '0},
    '{1'b1, 7'd65,  8'h02, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h55, 1'b0, 1'b0, '0},
    '{1'b1, 7'd64,  8'h10, 1'b1, 1'b1, '{1'b1, 7'd1, 32'd1, 32'd1,  32'd1}},
    '{1'b0, 7'd0,   8'h10, 1'b0, 1'b1, '{1'b0, 7'd1, 32'd1, 32'd2,  32'd2}},
    '{1'b0, 7'd0,   8'hEF, 1'b0, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PAGE_W-1:0]  in_page = '0;
  logic               in_start_run = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_page_fault;
  logic [SET_W-1:0]   out_set_size;
  logic [TOTAL_W-1:0] out_fault_total;
  logic [TOTAL_W-1:0] out_size_sum;
  logic [TOTAL_W-1:0] out_reference_total;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;

  working_set_fault_monitor u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_page             (in_page),
    .in_start_run        (in_start_run),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_page_fault      (out_page_fault),
    .out_set_size        (out_set_size),
    .out_fault_total     (out_fault_total),
    .out_size_sum        (out_size_sum),
    .out_reference_total (out_reference_total),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // window history and running totals as the block should hold them
  logic [PAGE_W-1:0]  page_hist [WINDOW_DEPTH];
  int unsigned        held_refs;
  int unsigned        oldest_slot;
  logic [TOTAL_W-1:0] fault_count;
  logic [TOTAL_W-1:0] size_count;
  logic [TOTAL_W-1:0] ref_count;
  logic [CFG_W-1:0]   window_reg = 7'd1;

  ws_report_t awaited_reports [$];
  int         error_count = 0;
  bit         gaps_on = 1'b1;
  bit         stalls_on = 1'b1;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  function automatic logic [TOTAL_W-1:0] clamp_add(input logic [TOTAL_W-1:0] acc,
                                                   input logic [TOTAL_W-1:0] inc);
    return (acc > TOTAL_MAX - inc) ? TOTAL_MAX : acc + inc;
  endfunction

  function automatic logic [SLOT_W-1:0] hist_slot(input int unsigned offset);
    return SLOT_W'((oldest_slot + offset) % WINDOW_DEPTH);
  endfunction

  function automatic ws_report_t track_reference(input logic [PAGE_W-1:0] page,
                                                 input logic start_run);
    ws_report_t  rep;
    int unsigned span, look, i, distinct;
    bit [255:0]  seen;
    logic [PAGE_W-1:0] p;
    if (start_run) begin
      held_refs   = 0;
      oldest_slot = 0;
      fault_count = '0;
      size_count  = '0;
      ref_count   = '0;
    end
    span = window_reg;
    if (span < 1) span = 1;
    if (span > WINDOW_DEPTH) span = WINDOW_DEPTH;
    look = (held_refs < span) ? held_refs : span;
    rep.page_fault = 1'b1;
    for (i = held_refs - look; i < held_refs; i++) begin
      if (page_hist[hist_slot(i)] == page) rep.page_fault = 1'b0;
    end
    if (held_refs >= span) begin
      oldest_slot = (oldest_slot + held_refs - (span - 1)) % WINDOW_DEPTH;
      held_refs   = span - 1;
    end
    page_hist[hist_slot(held_refs)] = page;
    held_refs++;
    seen = '0;
    distinct = 0;
    for (i = 0; i < held_refs; i++) begin
      p = page_hist[hist_slot(i)];
      if (!seen[p]) begin
        seen[p] = 1'b1;
        distinct++;
      end
    end
    if (distinct > SET_MAX) distinct = SET_MAX;
    rep.set_size        = SET_W'(distinct);
    fault_count         = clamp_add(fault_count, TOTAL_W'(rep.page_fault));
    size_count          = clamp_add(size_count, TOTAL_W'(distinct));
    ref_count           = clamp_add(ref_count, 1);
    rep.fault_total     = fault_count;
    rep.size_sum        = size_count;
    rep.reference_total = ref_count;
    return rep;
  endfunction

  task automatic send_reference(input logic [PAGE_W-1:0] page, input logic start_run,
                                input logic typed, input ws_report_t typed_rep);
    ws_report_t rep;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_page      <= page;
    in_start_run <= start_run;
    do @(posedge clk); while (!in_ready);
    rep = track_reference(page, start_run);
    if (typed) rep = typed_rep;
    awaited_reports = {awaited_reports, rep};
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    window_reg = value;
  endtask

  always @(posedge clk) begin
    ws_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          $error("result with no request pending");
          error_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (out_page_fault !== want.page_fault) begin
            $error("page_fault: expected %0d, got %0d", want.page_fault, out_page_fault);
            error_count++;
          end
          if (out_set_size !== want.set_size) begin
            $error("set_size: expected %0d, got %0d", want.set_size, out_set_size);
            error_count++;
          end
          if (out_fault_total !== want.fault_total) begin
            $error("fault_total: expected %0d, got %0d", want.fault_total, out_fault_total);
            error_count++;
          end
          if (out_size_sum !== want.size_sum) begin
            $error("size_sum: expected %0d, got %0d", want.size_sum, out_size_sum);
            error_count++;
          end
          if (out_reference_total !== want.reference_total) begin
            $error("reference_total: expected %0d, got %0d",
                   want.reference_total, out_reference_total);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0]  win;
    logic [PAGE_W-1:0] base, pg;
    logic              start;
    int                span;
    held_refs   = 0;
    oldest_slot = 0;
    fault_count = '0;
    size_count  = '0;
    ref_count   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (PAGE_ROWS[r].set_window) write_window(PAGE_ROWS[r].window);
      send_reference(PAGE_ROWS[r].page, PAGE_ROWS[r].start_run, PAGE_ROWS[r].typed,
                     PAGE_ROWS[r].report);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: win = 7'd1;
        1: win = 7'd64;
        2: win = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
        default: win = 7'($urandom_range(2, 63));
      endcase
      case ($urandom_range(0, 3))
        0: span = $urandom_range(1, 4);
        1: span = $urandom_range(5, 24);
        2: span = $urandom_range(25, 90);
        default: span = 256;
      endcase
      base = 8'($urandom_range(0, 255));
      write_window(win);
      gaps_on   = (ph < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_REFS; n++) begin
        start = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 9) == 0) pg = 8'($urandom_range(0, 255));
        else pg = 8'(base + $urandom_range(0, span - 1));
        send_reference(pg, start, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wsfm_pkg.sv
rtl/wsfm_cell.sv
rtl/wsfm_count.sv
rtl/working_set_fault_monitor.sv
rtl/wsfm_checker.sv
tb/tb_working_set_fault_monitor.sv
